// ----- rtl/core/mpps_pkg.sv -----
// Package for the modem power pulse sequencer: transaction types, state and
// phase codes, register map and reset values. No dependencies.
package mpps_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TickW    = 16;
  localparam int unsigned PollW    = 4;

  localparam logic [PollW-1:0] WaitLimit = 4'd3;
  localparam logic [PollW-1:0] CountMax  = 4'd15;

  // power state codes
  localparam logic [2:0] StUnknown = 3'd0;
  localparam logic [2:0] StOn      = 3'd1;
  localparam logic [2:0] StWaitOff = 3'd2;
  localparam logic [2:0] StOff     = 3'd3;
  localparam logic [2:0] StWaitOn  = 3'd4;

  // operation phase codes
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhPulse  = 2'd1;
  localparam logic [1:0] PhSettle = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_BLOCK = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_POWER = 2'd1,
    ACT_RESET = 2'd2
  } act_e;

  // register indexes
  localparam logic [2:0] RegPulseMode   = 3'd0;
  localparam logic [2:0] RegStartTicks  = 3'd1;
  localparam logic [2:0] RegStopTicks   = 3'd2;
  localparam logic [2:0] RegResetTicks  = 3'd3;
  localparam logic [2:0] RegSettleTicks = 3'd4;
  localparam logic [2:0] RegResetLine   = 3'd5;

  localparam logic [TickW-1:0] StartTicksRst  = 16'd1000;
  localparam logic [TickW-1:0] StopTicksRst   = 16'd1000;
  localparam logic [TickW-1:0] ResetTicksRst  = 16'd300;
  localparam logic [TickW-1:0] SettleTicksRst = 16'd20;

  typedef struct packed {
    logic [1:0] req_type;
    logic       modem_alive;
    logic       want_blocked;
  } req_t;

  typedef struct packed {
    logic       power_line;
    logic       reset_line;
    logic [2:0] power_state;
    logic       busy_res;
  } rsp_t;

  typedef struct packed {
    logic [2:0]       fsm;
    logic             active;
    logic [PollW-1:0] polls;
    logic [1:0]       phase;
    logic [TickW-1:0] timer;
    logic             from_req;
    logic             pwr;
    logic             rst;
  } seq_state_t;

endpackage

// ----- rtl/core/modem_power_pulse_sequencer.sv -----
// Top level of the modem power pulse sequencer: APB register block, input
// register, single-pass state update and result register. Uses mpps_pkg.

// Each transaction is a millisecond tick, a status poll or a block/unblock
// request; every one yields exactly one result with the power and reset line
// levels, the power state and a busy flag. A transaction is registered, then
// evaluated against the sequencer state and written to the result register,
// so the block takes one transaction per cycle while the output is not
// stalled. Pulse and settle lengths are counted in tick transactions, not in
// clock cycles. Registers (byte address 4*i): pulse_mode, start_pulse_ticks,
// stop_pulse_ticks, reset_pulse_ticks, settle_ticks, reset_line_present;
// write them only while no transaction is in flight.
module modem_power_pulse_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mpps_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mpps_pkg::rsp_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpps_pkg::CfgAddrW-1:0] paddr,
  input  logic [mpps_pkg::CfgDataW-1:0] pwdata,
  output logic [mpps_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic                         pulse_mode_q;
  logic [mpps_pkg::TickW-1:0]   start_ticks_q;
  logic [mpps_pkg::TickW-1:0]   stop_ticks_q;
  logic [mpps_pkg::TickW-1:0]   reset_ticks_q;
  logic [mpps_pkg::TickW-1:0]   settle_ticks_q;
  logic                         rline_q;
  logic                         cfg_we;
  logic [2:0]                   cfg_idx;

  logic                         s1_valid_q;
  mpps_pkg::req_t               s1_data_q;
  logic                         s1_adv;
  logic                         in_accept;

  mpps_pkg::seq_state_t         state_q;
  mpps_pkg::seq_state_t         state_d;
  logic                         out_valid_q;
  mpps_pkg::rsp_t               out_data_q;
  mpps_pkg::rsp_t               out_data_d;

  // configuration
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_mode_q   <= 1'b0;
      start_ticks_q  <= mpps_pkg::StartTicksRst;
      stop_ticks_q   <= mpps_pkg::StopTicksRst;
      reset_ticks_q  <= mpps_pkg::ResetTicksRst;
      settle_ticks_q <= mpps_pkg::SettleTicksRst;
      rline_q        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mpps_pkg::RegPulseMode:   pulse_mode_q   <= pwdata[0];
        mpps_pkg::RegStartTicks:  start_ticks_q  <= pwdata[mpps_pkg::TickW-1:0];
        mpps_pkg::RegStopTicks:   stop_ticks_q   <= pwdata[mpps_pkg::TickW-1:0];
        mpps_pkg::RegResetTicks:  reset_ticks_q  <= pwdata[mpps_pkg::TickW-1:0];
        mpps_pkg::RegSettleTicks: settle_ticks_q <= pwdata[mpps_pkg::TickW-1:0];
        mpps_pkg::RegResetLine:   rline_q        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      mpps_pkg::RegPulseMode:   prdata[0] = pulse_mode_q;
      mpps_pkg::RegStartTicks:  prdata[mpps_pkg::TickW-1:0] = start_ticks_q;
      mpps_pkg::RegStopTicks:   prdata[mpps_pkg::TickW-1:0] = stop_ticks_q;
      mpps_pkg::RegResetTicks:  prdata[mpps_pkg::TickW-1:0] = reset_ticks_q;
      mpps_pkg::RegSettleTicks: prdata[mpps_pkg::TickW-1:0] = settle_ticks_q;
      mpps_pkg::RegResetLine:   prdata[0] = rline_q;
      default: ;
    endcase
  end

  // handshake: input register feeds the result register
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_adv);
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  function automatic mpps_pkg::seq_state_t status_check(
    mpps_pkg::seq_state_t       s,
    logic                       alive,
    logic [mpps_pkg::TickW-1:0] start_len,
    logic [mpps_pkg::TickW-1:0] reset_len,
    logic                       rline
  );
    mpps_pkg::seq_state_t n;
    mpps_pkg::act_e       act;
    n   = s;
    act = mpps_pkg::ACT_NONE;
    if (!s.active && s.phase == mpps_pkg::PhIdle) begin
      if (n.polls != mpps_pkg::CountMax) begin
        n.polls = n.polls + 1'b1;
      end
      case (s.fsm)
        mpps_pkg::StOn: begin
          if (!alive) begin
            n.fsm = mpps_pkg::StWaitOn;
            act   = mpps_pkg::ACT_POWER;
          end
        end
        mpps_pkg::StOff: begin
          if (alive) n.fsm = mpps_pkg::StOn;
        end
        mpps_pkg::StWaitOn: begin
          if (alive) begin
            n.fsm = mpps_pkg::StOn;
          end else if (n.polls > mpps_pkg::WaitLimit) begin
            act = mpps_pkg::ACT_POWER;
          end
        end
        mpps_pkg::StWaitOff: begin
          if (!alive) begin
            n.fsm = mpps_pkg::StOff;
          end else if (rline && n.polls > mpps_pkg::WaitLimit) begin
            act = mpps_pkg::ACT_RESET;
          end
        end
        mpps_pkg::StUnknown: begin
          n.fsm = alive ? mpps_pkg::StOn : mpps_pkg::StOff;
        end
        default: ;
      endcase
      if (act != mpps_pkg::ACT_NONE) begin
        if (act == mpps_pkg::ACT_RESET) begin
          n.rst   = 1'b1;
          n.timer = reset_len;
        end else begin
          n.pwr   = 1'b1;
          n.timer = start_len;
        end
        n.phase    = mpps_pkg::PhPulse;
        n.from_req = 1'b0;
        n.active   = 1'b1;
      end
    end
    return n;
  endfunction

  // single-pass state update
  always_comb begin
    mpps_pkg::seq_state_t n;
    logic                 busy;
    logic [mpps_pkg::TickW-1:0] t;
    n    = state_q;
    busy = 1'b0;
    t    = state_q.timer;
    case (s1_data_q.req_type)
      mpps_pkg::REQ_TICK: begin
        if (state_q.phase != mpps_pkg::PhIdle) begin
          if (t != '0) t = t - 1'b1;
          n.timer = t;
          if (t == '0) begin
            if (state_q.phase == mpps_pkg::PhPulse) begin
              n.pwr = 1'b0;
              n.rst = 1'b0;
              if (state_q.from_req) begin
                n.phase = mpps_pkg::PhSettle;
                n.timer = settle_ticks_q;
              end else begin
                n.phase  = mpps_pkg::PhIdle;
                n.active = 1'b0;
                n.polls  = '0;
              end
            end else begin
              n.phase    = mpps_pkg::PhIdle;
              n.active   = 1'b0;
              n.polls    = '0;
              n.from_req = 1'b0;
              if (state_q.from_req && pulse_mode_q) begin
                n = status_check(n, s1_data_q.modem_alive, start_ticks_q,
                                 reset_ticks_q, rline_q);
              end
            end
          end
        end
      end
      mpps_pkg::REQ_POLL: begin
        if (pulse_mode_q) begin
          n = status_check(n, s1_data_q.modem_alive, start_ticks_q,
                           reset_ticks_q, rline_q);
        end
      end
      mpps_pkg::REQ_BLOCK: begin
        if (!pulse_mode_q) begin
          n.pwr      = s1_data_q.want_blocked;
          n.rst      = 1'b0;
          n.phase    = mpps_pkg::PhSettle;
          n.timer    = settle_ticks_q;
          n.from_req = 1'b0;
        end else begin
          if (n.fsm == mpps_pkg::StUnknown) begin
            n = status_check(n, s1_data_q.modem_alive, start_ticks_q,
                             reset_ticks_q, rline_q);
          end
          busy = n.active || n.phase != mpps_pkg::PhIdle;
          case (n.fsm)
            mpps_pkg::StOn: begin
              if (s1_data_q.want_blocked && !busy) begin
                n.fsm      = mpps_pkg::StWaitOff;
                n.pwr      = 1'b1;
                n.phase    = mpps_pkg::PhPulse;
                n.timer    = stop_ticks_q;
                n.from_req = 1'b1;
                n.active   = 1'b1;
              end
            end
            mpps_pkg::StOff: begin
              if (!s1_data_q.want_blocked && !busy) begin
                n.fsm      = mpps_pkg::StWaitOn;
                n.pwr      = 1'b1;
                n.phase    = mpps_pkg::PhPulse;
                n.timer    = start_ticks_q;
                n.from_req = 1'b1;
                n.active   = 1'b1;
              end
            end
            mpps_pkg::StWaitOff: begin
              if (!s1_data_q.want_blocked) begin
                n.fsm = n.active ? mpps_pkg::StWaitOn : mpps_pkg::StOn;
              end
            end
            mpps_pkg::StWaitOn: begin
              if (s1_data_q.want_blocked) begin
                n.fsm = n.active ? mpps_pkg::StWaitOff : mpps_pkg::StOff;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    state_d                = n;
    out_data_d.power_line  = n.pwr;
    out_data_d.reset_line  = n.rst;
    out_data_d.power_state = n.fsm;
    out_data_d.busy_res    = n.phase != mpps_pkg::PhIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv && s1_valid_q) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q)
    else $error("pending transaction dropped under stall");

  a_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_valid_q |=> out_data_q.busy_res == (state_q.phase != mpps_pkg::PhIdle))
    else $error("busy flag disagrees with phase");

  a_rst_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.rst |-> state_q.phase == mpps_pkg::PhPulse)
    else $error("reset line high outside a pulse");

  a_active_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.active |-> state_q.phase != mpps_pkg::PhIdle)
    else $error("operation active with idle phase");
`endif

endmodule
